>>> design/wfac_pkg.sv
// Shared types and constants of the worst-fit allocator.
package wfac_pkg;

   localparam int unsigned MAX_REQUESTS_DEF = 1024;
   localparam int unsigned MAX_BLOCKS_DEF   = 2048;
   localparam logic [31:0] HEAP_SIZE_RESET  = 32'd65536;
   localparam int unsigned ADDR_W           = 33;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   typedef struct packed {
      logic        action;
      logic [31:0] alloc_size;
      logic [10:0] request_index;
   } req_type;

   typedef struct packed {
      logic        granted;
      logic [31:0] start_address;
   } rsp_type;

endpackage

>>> design/wfac_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wfac_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

>>> design/wfac_scan.sv
// Scan unit: tracks the largest free block and the first unused entry.
module wfac_scan #(
   parameter int unsigned BW = 11,
   parameter int unsigned LW = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               clear,
   input  logic                               in_vld,
   input  logic [BW-1:0]                      in_idx,
   input  logic                               in_use,
   input  logic                               in_free,
   input  logic [wfac_pkg::ADDR_W-1:0]        in_start,
   input  logic [wfac_pkg::ADDR_W-1:0]        in_end,
   input  logic [LW-1:0]                      in_prev,
   input  logic [LW-1:0]                      in_next,
   output logic                               busy,
   output logic                               best_vld,
   output logic [BW-1:0]                      best_idx,
   output logic [wfac_pkg::ADDR_W-1:0]        best_len,
   output logic [wfac_pkg::ADDR_W-1:0]        best_start,
   output logic [wfac_pkg::ADDR_W-1:0]        best_end,
   output logic [LW-1:0]                      best_prev,
   output logic [LW-1:0]                      best_next,
   output logic                               fresh_vld,
   output logic [BW-1:0]                      fresh_idx
);
   import wfac_pkg::*;

   logic              s1_vld_ff, s1_cand_ff, s1_unused_ff;
   logic [BW-1:0]     s1_idx_ff;
   logic [ADDR_W-1:0] s1_len_ff, s1_start_ff, s1_end_ff;
   logic [LW-1:0]     s1_prev_ff, s1_next_ff;
   logic              take;

   // stage one: length of the block
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= in_vld;
      end
      s1_cand_ff   <= in_use & in_free;
      s1_unused_ff <= ~in_use;
      s1_idx_ff    <= in_idx;
      s1_len_ff    <= in_end - in_start;
      s1_start_ff  <= in_start;
      s1_end_ff    <= in_end;
      s1_prev_ff   <= in_prev;
      s1_next_ff   <= in_next;
   end

   // larger block wins, lower start breaks a tie
   assign take = s1_vld_ff && s1_cand_ff &&
                 (!best_vld || (s1_len_ff > best_len) ||
                  ((s1_len_ff == best_len) && (s1_start_ff < best_start)));

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         best_vld  <= 1'b0;
         fresh_vld <= 1'b0;
      end else begin
         if (take) begin
            best_vld <= 1'b1;
         end
         if (s1_vld_ff && s1_unused_ff && !fresh_vld) begin
            fresh_vld <= 1'b1;
         end
      end
      if (take) begin
         best_idx   <= s1_idx_ff;
         best_len   <= s1_len_ff;
         best_start <= s1_start_ff;
         best_end   <= s1_end_ff;
         best_prev  <= s1_prev_ff;
         best_next  <= s1_next_ff;
      end
      if (s1_vld_ff && s1_unused_ff && !fresh_vld) begin
         fresh_idx <= s1_idx_ff;
      end
   end

   assign busy = s1_vld_ff;
endmodule

>>> design/worst_fit_allocator_coalescing.sv
// Top level of the worst-fit heap allocator with coalescing of free neighbors.
//
// Usage:
//  - req channel (req_valid / req_stall / req_data): one transfer per request,
//    either allocate (alloc_size cells) or free (an earlier request number).
//    Every request takes the next request number from 1 while any remain.
//  - rsp channel (rsp_valid / rsp_stall / rsp_data): one transfer per
//    allocate, carrying granted and the start address (0 when refused).
//    A free gives no transfer.
//  - csr port: csr_wr_en with csr_wr_data sets the heap size and restarts
//    the heap as after reset.
// One request at a time. An allocate sweeps every block entry through the
// block memory read port; a refused allocate of size zero or with request
// numbers used up skips the sweep. A free follows the chain of dependent
// block memory reads for the block and its neighbors.
// Reset or a heap size write starts a clearing pass over the block and
// request memories during which req_stall is high.
// A stalled result holds in the output register; the next request is still
// taken, and its own result waits until the register drains.
module worst_fit_allocator_coalescing #(
   parameter int unsigned MAX_REQUESTS = wfac_pkg::MAX_REQUESTS_DEF,
   parameter int unsigned MAX_BLOCKS   = wfac_pkg::MAX_BLOCKS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  wfac_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output wfac_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data
);
   import wfac_pkg::*;

   localparam int unsigned BW    = $clog2(MAX_BLOCKS);
   localparam int unsigned LW    = BW + 1;
   localparam int unsigned RW    = $clog2(MAX_REQUESTS);
   localparam int unsigned NW    = $clog2(MAX_REQUESTS + 1);
   localparam int unsigned CLR_N = (MAX_BLOCKS > MAX_REQUESTS) ? MAX_BLOCKS : MAX_REQUESTS;
   localparam int unsigned CW    = $clog2(CLR_N) + 1;
   localparam int unsigned EW    = 2 + 2 * ADDR_W + 2 * LW;
   localparam logic [LW-1:0] NIL = LW'(MAX_BLOCKS);

   typedef enum logic [14:0] {
      ST_CLEAR  = 15'b000000000000001,
      ST_IDLE   = 15'b000000000000010,
      ST_SCAN   = 15'b000000000000100,
      ST_DECIDE = 15'b000000000001000,
      ST_A_LINK = 15'b000000000010000,
      ST_A_BEST = 15'b000000000100000,
      ST_RESULT = 15'b000000001000000,
      ST_F_REQ  = 15'b000000010000000,
      ST_F_B    = 15'b000000100000000,
      ST_F_N    = 15'b000001000000000,
      ST_F_NN   = 15'b000010000000000,
      ST_F_P0   = 15'b000100000000000,
      ST_F_P    = 15'b001000000000000,
      ST_F_PP   = 15'b010000000000000,
      ST_F_WB   = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;

   // memory ports
   logic              blk_wr_en;
   logic [BW-1:0]     blk_wr_addr, blk_rd_addr;
   logic [EW-1:0]     blk_wr_data, blk_rd_data;
   logic              req_wr_en;
   logic [RW-1:0]     req_wr_addr, req_rd_addr;
   logic [LW-1:0]     req_wr_data, req_rd_data;

   // write fields and read fields of a block entry
   logic              w_use, w_free;
   logic [ADDR_W-1:0] w_start, w_end;
   logic [LW-1:0]     w_prev, w_next;
   logic              rd_use, rd_free;
   logic [ADDR_W-1:0] rd_start, rd_end;
   logic [LW-1:0]     rd_prev, rd_next;

   assign blk_wr_data = {w_use, w_free, w_start, w_end, w_prev, w_next};
   assign {rd_use, rd_free, rd_start, rd_end, rd_prev, rd_next} = blk_rd_data;

   // registers
   logic [31:0]       heap_ff, heap_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [NW-1:0]     num_ff, num_in;
   logic              v0_ff, v0_in;
   logic [BW-1:0]     v0_idx_ff;
   logic [31:0]       size_ff, size_in;
   logic [RW-1:0]     slot_ff, slot_in;
   logic [BW-1:0]     b_ff, b_in;
   logic              cur_use_ff, cur_use_in;
   logic [ADDR_W-1:0] cur_start_ff, cur_start_in, cur_end_ff, cur_end_in;
   logic [LW-1:0]     cur_prev_ff, cur_prev_in, cur_next_ff, cur_next_in;
   logic              res_gnt_ff, res_gnt_in;
   logic [31:0]       res_addr_ff, res_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // scan unit
   logic              scan_clear, scan_busy;
   logic              best_vld, fresh_vld;
   logic [BW-1:0]     best_idx, fresh_idx;
   logic [ADDR_W-1:0] best_len, best_start, best_end;
   logic [LW-1:0]     best_prev, best_next;

   logic              accept, have_num, idx_ok, issue, rsp_load;
   logic [ADDR_W-1:0] split_at;

   wfac_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_blk_ram (
      .clock   (clock),
      .wr_en   (blk_wr_en),
      .wr_addr (blk_wr_addr),
      .wr_data (blk_wr_data),
      .rd_addr (blk_rd_addr),
      .rd_data (blk_rd_data)
   );

   wfac_ram #(.WIDTH(LW), .DEPTH(MAX_REQUESTS)) u_req_ram (
      .clock   (clock),
      .wr_en   (req_wr_en),
      .wr_addr (req_wr_addr),
      .wr_data (req_wr_data),
      .rd_addr (req_rd_addr),
      .rd_data (req_rd_data)
   );

   wfac_scan #(.BW(BW), .LW(LW)) u_scan (
      .clock      (clock),
      .reset      (reset),
      .clear      (scan_clear),
      .in_vld     (v0_ff),
      .in_idx     (v0_idx_ff),
      .in_use     (rd_use),
      .in_free    (rd_free),
      .in_start   (rd_start),
      .in_end     (rd_end),
      .in_prev    (rd_prev),
      .in_next    (rd_next),
      .busy       (scan_busy),
      .best_vld   (best_vld),
      .best_idx   (best_idx),
      .best_len   (best_len),
      .best_start (best_start),
      .best_end   (best_end),
      .best_prev  (best_prev),
      .best_next  (best_next),
      .fresh_vld  (fresh_vld),
      .fresh_idx  (fresh_idx)
   );

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign have_num = (32'(num_ff) < 32'(MAX_REQUESTS));
   assign idx_ok   = (req_data.request_index != 11'd0) &&
                     (32'(req_data.request_index) <= 32'(MAX_REQUESTS));
   assign issue    = (state_ff == ST_SCAN) && (32'(cnt_ff) < 32'(MAX_BLOCKS));
   assign split_at = best_start + ADDR_W'(size_ff);
   assign rsp_load = (state_ff == ST_RESULT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      heap_in      = heap_ff;
      cnt_in       = cnt_ff;
      num_in       = num_ff;
      v0_in        = issue;
      size_in      = size_ff;
      slot_in      = slot_ff;
      b_in         = b_ff;
      cur_use_in   = cur_use_ff;
      cur_start_in = cur_start_ff;
      cur_end_in   = cur_end_ff;
      cur_prev_in  = cur_prev_ff;
      cur_next_in  = cur_next_ff;
      res_gnt_in   = res_gnt_ff;
      res_addr_in  = res_addr_ff;
      scan_clear   = 1'b0;
      blk_wr_en    = 1'b0;
      blk_wr_addr  = b_ff;
      blk_rd_addr  = cnt_ff[BW-1:0];
      w_use        = 1'b0;
      w_free       = 1'b0;
      w_start      = rd_start;
      w_end        = rd_end;
      w_prev       = NIL;
      w_next       = NIL;
      req_wr_en    = 1'b0;
      req_wr_addr  = slot_ff;
      req_wr_data  = NIL;
      req_rd_addr  = RW'(32'(req_data.request_index) - 32'd1);

      unique case (state_ff)
         ST_CLEAR: begin
            // one block entry and one request entry a cycle
            blk_wr_en   = (32'(cnt_ff) < 32'(MAX_BLOCKS));
            blk_wr_addr = cnt_ff[BW-1:0];
            if (cnt_ff == '0) begin
               w_use   = 1'b1;
               w_free  = 1'b1;
               w_start = ADDR_W'(1);
               w_end   = ADDR_W'(heap_ff) + ADDR_W'(1);
            end
            req_wr_en   = (32'(cnt_ff) < 32'(MAX_REQUESTS));
            req_wr_addr = cnt_ff[RW-1:0];
            if (32'(cnt_ff) == 32'(CLR_N - 1)) begin
               state_in = ST_IDLE;
               num_in   = '0;
            end
            cnt_in = cnt_ff + CW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               if (have_num) begin
                  num_in = num_ff + NW'(1);
               end
               if (req_data.action == ACT_FREE) begin
                  slot_in = req_rd_addr;
                  if (idx_ok) begin
                     state_in = ST_F_REQ;
                  end
               end else if (have_num && (req_data.alloc_size != 32'd0)) begin
                  size_in    = req_data.alloc_size;
                  slot_in    = num_ff[RW-1:0];
                  cnt_in     = '0;
                  scan_clear = 1'b1;
                  state_in   = ST_SCAN;
               end else begin
                  res_gnt_in  = 1'b0;
                  res_addr_in = '0;
                  state_in    = ST_RESULT;
               end
            end
         end
         ST_SCAN: begin
            // issue one read a cycle, then drain the scan pipeline
            if (issue) begin
               cnt_in = cnt_ff + CW'(1);
            end else if (!v0_ff && !scan_busy) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            res_gnt_in  = 1'b0;
            res_addr_in = '0;
            state_in    = ST_RESULT;
            if (best_vld && (best_len >= ADDR_W'(size_ff))) begin
               if (best_len == ADDR_W'(size_ff)) begin
                  blk_wr_en   = 1'b1;
                  blk_wr_addr = best_idx;
                  w_use       = 1'b1;
                  w_start     = best_start;
                  w_end       = best_end;
                  w_prev      = best_prev;
                  w_next      = best_next;
                  req_wr_en   = 1'b1;
                  req_wr_data = LW'(best_idx);
                  res_gnt_in  = 1'b1;
                  res_addr_in = best_start[31:0];
               end else if (fresh_vld) begin
                  // carve the low end into the unused entry
                  blk_wr_en   = 1'b1;
                  blk_wr_addr = fresh_idx;
                  w_use       = 1'b1;
                  w_start     = best_start;
                  w_end       = split_at;
                  w_prev      = best_prev;
                  w_next      = LW'(best_idx);
                  req_wr_en   = 1'b1;
                  req_wr_data = LW'(fresh_idx);
                  blk_rd_addr = best_prev[BW-1:0];
                  res_gnt_in  = 1'b1;
                  res_addr_in = best_start[31:0];
                  state_in    = (best_prev < NIL) ? ST_A_LINK : ST_A_BEST;
               end
            end
         end
         ST_A_LINK: begin
            blk_wr_en   = 1'b1;
            blk_wr_addr = best_prev[BW-1:0];
            w_use       = rd_use;
            w_free      = rd_free;
            w_prev      = rd_prev;
            w_next      = LW'(fresh_idx);
            state_in    = ST_A_BEST;
         end
         ST_A_BEST: begin
            blk_wr_en   = 1'b1;
            blk_wr_addr = best_idx;
            w_use       = 1'b1;
            w_free      = 1'b1;
            w_start     = split_at;
            w_end       = best_end;
            w_prev      = LW'(fresh_idx);
            w_next      = best_next;
            state_in    = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         ST_F_REQ: begin
            b_in        = req_rd_data[BW-1:0];
            blk_rd_addr = req_rd_data[BW-1:0];
            state_in    = (req_rd_data < NIL) ? ST_F_B : ST_IDLE;
         end
         ST_F_B: begin
            if (!rd_use) begin
               state_in = ST_IDLE;
            end else begin
               req_wr_en    = 1'b1;
               cur_use_in   = 1'b1;
               cur_start_in = rd_start;
               cur_end_in   = rd_end;
               cur_prev_in  = rd_prev;
               cur_next_in  = rd_next;
               blk_rd_addr  = rd_next[BW-1:0];
               state_in     = (rd_next < NIL) ? ST_F_N : ST_F_P0;
            end
         end
         ST_F_N: begin
            state_in = ST_F_P0;
            if (rd_free) begin
               // absorb the successor and drop its entry
               cur_end_in  = rd_end;
               cur_next_in = rd_next;
               blk_wr_en   = 1'b1;
               blk_wr_addr = cur_next_ff[BW-1:0];
               blk_rd_addr = rd_next[BW-1:0];
               if (rd_next < NIL) begin
                  state_in = ST_F_NN;
               end
            end
         end
         ST_F_NN: begin
            blk_wr_en   = 1'b1;
            blk_wr_addr = cur_next_ff[BW-1:0];
            w_use       = rd_use;
            w_free      = rd_free;
            w_prev      = LW'(b_ff);
            w_next      = rd_next;
            state_in    = ST_F_P0;
         end
         ST_F_P0: begin
            blk_rd_addr = cur_prev_ff[BW-1:0];
            state_in    = (cur_prev_ff < NIL) ? ST_F_P : ST_F_WB;
         end
         ST_F_P: begin
            state_in = ST_F_WB;
            if (rd_free) begin
               // absorb the predecessor and drop its entry
               cur_start_in = rd_start;
               cur_prev_in  = rd_prev;
               blk_wr_en    = 1'b1;
               blk_wr_addr  = cur_prev_ff[BW-1:0];
               blk_rd_addr  = rd_prev[BW-1:0];
               if (rd_prev < NIL) begin
                  state_in = ST_F_PP;
               end
            end
         end
         ST_F_PP: begin
            blk_wr_en   = 1'b1;
            blk_wr_addr = cur_prev_ff[BW-1:0];
            w_use       = rd_use;
            w_free      = rd_free;
            w_prev      = rd_prev;
            w_next      = LW'(b_ff);
            state_in    = ST_F_WB;
         end
         ST_F_WB: begin
            blk_wr_en   = 1'b1;
            blk_wr_addr = b_ff;
            w_use       = cur_use_ff;
            w_free      = 1'b1;
            w_start     = cur_start_ff;
            w_end       = cur_end_ff;
            w_prev      = cur_prev_ff;
            w_next      = cur_next_ff;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      // a heap size write restarts the heap
      if (csr_wr_en) begin
         heap_in  = csr_wr_data;
         cnt_in   = '0;
         state_in = ST_CLEAR;
      end
   end

   // output register: drop on transfer, load a finished result
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.granted       = res_gnt_ff;
         rsp_data_in.start_address = res_addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         heap_ff      <= HEAP_SIZE_RESET;
         cnt_ff       <= '0;
         num_ff       <= '0;
         v0_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         heap_ff      <= heap_in;
         cnt_ff       <= cnt_in;
         num_ff       <= num_in;
         v0_ff        <= v0_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      v0_idx_ff    <= cnt_ff[BW-1:0];
      size_ff      <= size_in;
      slot_ff      <= slot_in;
      b_ff         <= b_in;
      cur_use_ff   <= cur_use_in;
      cur_start_ff <= cur_start_in;
      cur_end_ff   <= cur_end_in;
      cur_prev_ff  <= cur_prev_in;
      cur_next_ff  <= cur_next_in;
      res_gnt_ff   <= res_gnt_in;
      res_addr_ff  <= res_addr_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule
